/* src/sorted_deadline_timer_queue_core_defines.svh */
// assertion macros for the sorted deadline timer queue
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define SDTQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdtq assertion failed");

// next-cycle implication
`define SDTQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdtq assertion failed");

`endif

/* src/sdtq_pkg.sv */
// shared constants and types of the sorted deadline timer queue
`default_nettype none

package sdtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);

  localparam int TIME_W   = 48;
  localparam int HANDLE_W = 32;
  localparam int DELAY_W  = 32;
  localparam int WIN_W    = 20;
  localparam int KIND_W   = 2;
  localparam int MULT_W   = 10;
  localparam int PROD_W   = DELAY_W + MULT_W;

  localparam logic [MULT_W-1:0] US_PER_MS    = 10'd1000;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 20'd50000;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_OK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd2;

  typedef struct packed {
    logic              latch;
    logic              mul;
    logic              add;
    logic              adv;
    logic              lim;
    logic              ins;
    logic              pop;
    logic              load_out;
    logic [KIND_W-1:0] out_kind;
    logic              out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic full;
    logic empty;
    logic head_due;
    logic more_due;
  } dp_stat_t;

endpackage

`default_nettype wire

/* src/sdtq_in_if.sv */
// input channel of the sorted deadline timer queue
`default_nettype none

interface sdtq_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [sdtq_pkg::DELAY_W-1:0]   delay_ms;
  logic [sdtq_pkg::HANDLE_W-1:0]  handle;
  logic [sdtq_pkg::WIN_W-1:0]     elapsed_us;

  modport source (output valid, cmd, delay_ms, handle, elapsed_us, input ready);
  modport sink (input valid, cmd, delay_ms, handle, elapsed_us, output ready);
endinterface

`default_nettype wire

/* src/sdtq_out_if.sv */
// result channel of the sorted deadline timer queue
`default_nettype none

interface sdtq_out_if;
  logic                           valid;
  logic                           ready;
  logic [sdtq_pkg::KIND_W-1:0]    kind;
  logic [sdtq_pkg::HANDLE_W-1:0]  handle_out;
  logic                           new_earliest;
  logic                           last;

  modport source (output valid, kind, handle_out, new_earliest, last, input ready);
  modport sink (input valid, kind, handle_out, new_earliest, last, output ready);
endinterface

`default_nettype wire

/* src/sdtq_ctrl.sv */
// sequencing state machine of the sorted deadline timer queue
`default_nettype none

module sdtq_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  input  wire sdtq_pkg::dp_stat_t stat_i,
  output sdtq_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ADD  = 4'd3;
  localparam logic [3:0] ST_INS  = 4'd4;
  localparam logic [3:0] ST_FULL = 4'd5;
  localparam logic [3:0] ST_ADV  = 4'd6;
  localparam logic [3:0] ST_LIM  = 4'd7;
  localparam logic [3:0] ST_FIRE = 4'd8;

  localparam int RW = sdtq_pkg::RES_W;

  logic [3:0]    state_q, state_d;
  logic [RW-1:0] n_q, n_d;
  logic          first_q, first_d;
  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic          fire_last;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign fire_last   = !(stat_i.more_due && (n_q < RW'(sdtq_pkg::MAX_RESULTS - 1)));

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    first_d  = first_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISP;
        end
      end
      ST_DISP: begin
        if (stat_i.is_tick) begin
          state_d = ST_ADV;
        end else if (stat_i.full) begin
          state_d = ST_FULL;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_INS;
      end
      ST_INS: begin
        if (out_free) begin
          cmd_o.ins      = 1'b1;
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = sdtq_pkg::KIND_OK;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = sdtq_pkg::KIND_FULL;
          cmd_o.out_last = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_LIM;
      end
      ST_LIM: begin
        cmd_o.lim = 1'b1;
        n_d       = '0;
        first_d   = 1'b1;
        state_d   = ST_FIRE;
      end
      ST_FIRE: begin
        if (first_q && !stat_i.head_due) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.pop      = 1'b1;
          cmd_o.load_out = 1'b1;
          cmd_o.out_kind = sdtq_pkg::KIND_FIRED;
          cmd_o.out_last = fire_last;
          n_d            = n_q + RW'(1);
          first_d        = 1'b0;
          if (fire_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* src/sdtq_dp.sv */
// clock, sorted entry row and result register of the timer queue
`default_nettype none

module sdtq_dp #(
  parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [sdtq_pkg::WIN_W-1:0]          cfg_wdata_i,
  input  wire                                 in_cmd_i,
  input  wire  [sdtq_pkg::DELAY_W-1:0]        in_delay_ms_i,
  input  wire  [sdtq_pkg::HANDLE_W-1:0]       in_handle_i,
  input  wire  [sdtq_pkg::WIN_W-1:0]          in_elapsed_us_i,
  input  wire sdtq_pkg::ctrl_cmd_t            cmd_i,
  output sdtq_pkg::dp_stat_t                  stat_o,
  output logic [sdtq_pkg::KIND_W-1:0]         kind_o,
  output logic [sdtq_pkg::HANDLE_W-1:0]       handle_out_o,
  output logic                                new_earliest_o,
  output logic                                last_o
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = sdtq_pkg::TIME_W;
  localparam int HW    = sdtq_pkg::HANDLE_W;
  localparam int PW    = sdtq_pkg::PROD_W;

  logic [TW-1:0]                 now_q;
  logic [sdtq_pkg::WIN_W-1:0]    win_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          tick_q;
  logic [sdtq_pkg::DELAY_W-1:0]  delay_q;
  logic [HW-1:0]                 handle_q;
  logic [sdtq_pkg::WIN_W-1:0]    elapsed_q;
  logic [PW-1:0]                 prod_q;
  logic [TW-1:0]                 dl_q;
  logic [TW:0]                   lim_q;

  logic [TW-1:0] dl_arr_q [QUEUE_DEPTH];
  logic [TW-1:0] dl_arr_d [QUEUE_DEPTH];
  logic [HW-1:0] hd_arr_q [QUEUE_DEPTH];
  logic [HW-1:0] hd_arr_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] keep;

  // each cell keeps its entry when it is valid and due before the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < cnt_q) && (dl_arr_q[i] < dl_q);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      dl_arr_d[i] = dl_arr_q[i];
      hd_arr_d[i] = hd_arr_q[i];
    end
    if (cmd_i.ins) begin
      if (!keep[0]) begin
        dl_arr_d[0] = dl_q;
        hd_arr_d[0] = handle_q;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!keep[i]) begin
          if (keep[i-1]) begin
            dl_arr_d[i] = dl_q;
            hd_arr_d[i] = handle_q;
          end else begin
            dl_arr_d[i] = dl_arr_q[i-1];
            hd_arr_d[i] = hd_arr_q[i-1];
          end
        end
      end
    end else if (cmd_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        dl_arr_d[i] = dl_arr_q[i+1];
        hd_arr_d[i] = hd_arr_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      dl_arr_q[i] <= dl_arr_d[i];
      hd_arr_q[i] <= hd_arr_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      win_q <= sdtq_pkg::WINDOW_RESET;
      cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (cmd_i.adv) begin
        now_q <= now_q + TW'(elapsed_q);
      end
      if (cmd_i.ins) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      tick_q    <= (in_cmd_i == sdtq_pkg::CMD_TICK);
      delay_q   <= in_delay_ms_i;
      handle_q  <= in_handle_i;
      elapsed_q <= in_elapsed_us_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(delay_q) * PW'(sdtq_pkg::US_PER_MS);
    end
    if (cmd_i.add) begin
      dl_q <= now_q + TW'(prod_q);
    end
    if (cmd_i.lim) begin
      lim_q <= {1'b0, now_q} + (TW + 1)'(win_q);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      kind_o         <= cmd_i.out_kind;
      last_o         <= cmd_i.out_last;
      handle_out_o   <= (cmd_i.out_kind == sdtq_pkg::KIND_FIRED) ? hd_arr_q[0] : handle_q;
      new_earliest_o <= (cmd_i.out_kind == sdtq_pkg::KIND_OK) && !keep[0];
    end
  end

  assign stat_o.is_tick  = tick_q;
  assign stat_o.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.head_due = (cnt_q != '0) && (dl_arr_q[0] <= now_q);
  assign stat_o.more_due = (cnt_q > CNT_W'(1)) && ({1'b0, dl_arr_q[1]} < lim_q);

endmodule

`default_nettype wire

/* src/sorted_deadline_timer_queue_core.sv */
// top level of the sorted deadline timer queue
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    cmd, delay_ms, handle, elapsed_us
//  out_o    out  valid/ready    kind, handle_out, new_earliest, last
//  cfg      in   cfg_we_i       cfg_wdata_i (fire_window_us)
//
// a set runs dispatch, mul, add, insert; a full queue answer dispatch, full
// a tick advances, limits, fires one per cycle while out_o is free, up to 16
// a tick that fires nothing goes back to idle with no transaction
// one transaction is in flight; in_i is ready only when the sequencer is idle
// a stalled result register holds the sequencer until out_o takes it
// reset zeroes clock and entry count, presets the window; entries need none
`default_nettype none
`include "sorted_deadline_timer_queue_core_defines.svh"

module sorted_deadline_timer_queue_core #(
  parameter int QUEUE_DEPTH = sdtq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [sdtq_pkg::WIN_W-1:0]  cfg_wdata_i,
  sdtq_in_if.sink                     in_i,
  sdtq_out_if.source                  out_o
);

  sdtq_pkg::ctrl_cmd_t cmd;
  sdtq_pkg::dp_stat_t  stat;

  sdtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdtq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_cmd_i        (in_i.cmd),
    .in_delay_ms_i   (in_i.delay_ms),
    .in_handle_i     (in_i.handle),
    .in_elapsed_us_i (in_i.elapsed_us),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_o          (out_o.kind),
    .handle_out_o    (out_o.handle_out),
    .new_earliest_o  (out_o.new_earliest),
    .last_o          (out_o.last)
  );

  `SDTQ_ASSERT_NEXT(a_one_in_flight, in_i.valid && in_i.ready, !in_i.ready)
  `SDTQ_ASSERT_IMPL(a_fire_nonempty, cmd.load_out && (cmd.out_kind == sdtq_pkg::KIND_FIRED), !stat.empty)
  `SDTQ_ASSERT_IMPL(a_ins_not_full, cmd.ins, !stat.full)
  `SDTQ_ASSERT_IMPL(a_load_free, cmd.load_out, !out_o.valid || out_o.ready)

endmodule

`default_nettype wire
